FILE: rtl/assert_macros.svh
// Assertion macros included by binomial_mod_m.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/bmm_pkg.sv
// Types shared by the binomial-mod-m block.
package bmm_pkg;

	typedef struct packed {
		logic [15:0] n_value;
		logic [15:0] r_value;
		logic [31:0] modulus;
	} bmm_in_t;

	typedef struct packed {
		logic [31:0] residue;
		logic        error;
	} bmm_out_t;

	// Status of an iterative arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

FILE: rtl/bmm_map.sv
// Prime map memory with the post-reset sieve and a lookup read port.
module bmm_map #(
	parameter int MAP_SIZE = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(MAP_SIZE)-1:0] rd_addr,
	output logic                        rd_data,
	output logic                        ready
);
	import bmm_pkg::*;

	localparam int ADDR_W = $clog2(MAP_SIZE);

	typedef enum logic [4:0] {
		M_CLR  = 5'b00001,
		M_IRD  = 5'b00010,
		M_ICHK = 5'b00100,
		M_MARK = 5'b01000,
		M_DONE = 5'b10000
	} map_state_t;

	map_state_t          state_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]   i_q;
	logic [ADDR_W:0]     j_q;
	logic [2*ADDR_W-1:0] sq;
	logic                mem [MAP_SIZE];
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic                wdata;
	logic [ADDR_W-1:0]   raddr;
	logic                rd_q;

	assign sq = i_q * i_q;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = 1'b0;
		raddr = rd_addr;
		unique case (state_q)
			M_CLR: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = (cnt_q < ADDR_W'(2));
			end
			M_IRD: raddr = i_q;
			M_MARK: begin
				we    = (j_q < (ADDR_W+1)'(MAP_SIZE));
				waddr = j_q[ADDR_W-1:0];
				wdata = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign rd_data = rd_q;
	assign ready   = (state_q == M_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_CLR;
			cnt_q   <= '0;
			i_q     <= ADDR_W'(2);
			j_q     <= '0;
		end else begin
			unique case (state_q)
				M_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(MAP_SIZE - 1))
						state_q <= M_IRD;
				end
				M_IRD: begin
					if (sq >= (2*ADDR_W)'(MAP_SIZE))
						state_q <= M_DONE;
					else
						state_q <= M_ICHK;
				end
				M_ICHK: begin
					if (!rd_q) begin
						j_q     <= sq[ADDR_W:0];
						state_q <= M_MARK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= M_IRD;
					end
				end
				M_MARK: begin
					if (j_q >= (ADDR_W+1)'(MAP_SIZE)) begin
						i_q     <= i_q + 1'b1;
						state_q <= M_IRD;
					end else begin
						j_q <= j_q + {1'b0, i_q};
					end
				end
				M_DONE: ;
				default: state_q <= M_CLR;
			endcase
		end
	end
endmodule

FILE: rtl/bmm_div16.sv
// Restoring 16-bit divider, one quotient bit per cycle.
module bmm_div16 (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         dividend,
	input  logic [15:0]         divisor,
	output logic [15:0]         quotient,
	output bmm_pkg::unit_stat_t stat
);
	import bmm_pkg::*;

	logic [15:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [16:0] sh;
	logic        ge;

	assign sh = {rem_q, quo_q[15]};
	assign ge = (sh >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? 16'(sh - {1'b0, dvs_q}) : sh[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 5'd1);
			if (start)
				cnt_q <= 5'd16;
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
endmodule

FILE: rtl/bmm_mulmod.sv
// Modular multiplier: one 32x32 product, then a bit-serial remainder by m.
module bmm_mulmod (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	input  logic [31:0]         m,
	output logic [31:0]         res,
	output bmm_pkg::unit_stat_t stat
);
	import bmm_pkg::*;

	logic [63:0] prod_q;
	logic [31:0] rem_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [32:0] sh;
	logic        ge;

	assign sh = {rem_q, prod_q[63]};
	assign ge = (sh >= {1'b0, m});

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= a * b;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? 32'(sh - {1'b0, m}) : sh[31:0];
			prod_q <= {prod_q[62:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (start)
				cnt_q <= 7'd64;
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign res       = rem_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
endmodule

FILE: rtl/binomial_mod_m.sv
// Binomial coefficient C(n,r) mod m by Legendre exponents over a sieved prime map.
// After reset the sieve sweeps the map; busy stays high until it ends. Modulus zero or
// r above n: result in the cycle after transfer. Otherwise every index up to n is looked
// up in the map, and each prime takes three divisions per base-p digit of n (shared
// divider) and one multiply per unit of exponent (bit-serial mod-m multiplier).
// One item at a time; each result shows for one cycle on strobe and cannot be stalled.
`include "assert_macros.svh"
module binomial_mod_m #(
	parameter int MAX_N = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bmm_pkg::bmm_in_t  item,
	output logic              strobe,
	output bmm_pkg::bmm_out_t result
);
	import bmm_pkg::*;

	localparam int MAP_SIZE = (MAX_N > 65536) ? MAX_N : 65536;
	localparam int ADDR_W   = $clog2(MAP_SIZE);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOOP = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_DN   = 7'b0001000,
		S_DR   = 7'b0010000,
		S_DD   = 7'b0100000,
		S_MUL  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [15:0] n_q;
	logic [31:0] m_q;
	logic [16:0] p_q;
	logic [31:0] acc_q;
	logic [15:0] qn_q;
	logic [15:0] qr_q;
	logic [15:0] qd_q;
	logic [4:0]  e_q;
	logic        launched_q;
	logic        strobe_q;
	bmm_out_t    result_q;
	logic [15:0] r_keep_q;

	logic        map_ready;
	logic        map_data;
	logic        accept;
	logic        div_start;
	logic [15:0] div_dividend;
	logic [15:0] div_quo;
	unit_stat_t  div_stat;
	logic        mul_start;
	logic [31:0] mul_res;
	unit_stat_t  mul_stat;
	logic [15:0] carry;
	logic [4:0]  e_new;
	logic        strobe_d;
	bmm_out_t    result_d;

	bmm_map #(.MAP_SIZE(MAP_SIZE)) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (ADDR_W'(p_q[15:0])),
		.rd_data (map_data),
		.ready   (map_ready)
	);

	bmm_div16 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (p_q[15:0]),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	bmm_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (acc_q),
		.b      ({16'd0, p_q[15:0]}),
		.m      (m_q),
		.res    (mul_res),
		.stat   (mul_stat)
	);

	assign busy   = !map_ready || (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		unique case (state_q)
			S_DR:    div_dividend = qr_q;
			S_DD:    div_dividend = qd_q;
			default: div_dividend = qn_q;
		endcase
	end

	assign div_start = !launched_q && !div_stat.busy &&
		((state_q == S_DN) || (state_q == S_DR) || (state_q == S_DD));
	assign mul_start = !launched_q && !mul_stat.busy && (state_q == S_MUL);

	// One digit position of the carry count: floor terms differ by zero or one.
	assign carry = qn_q - qr_q - div_quo;
	assign e_new = e_q + {4'd0, carry[0]};

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= item.n_value;
			m_q   <= item.modulus;
			acc_q <= (item.modulus == 32'd1) ? 32'd0 : 32'd1;
		end
		unique case (state_q)
			S_CHK: begin
				qn_q <= n_q;
				qr_q <= qr_q;
				qd_q <= 16'(n_q - qr_q);
			end
			S_DN: if (div_stat.done) qn_q <= div_quo;
			S_DR: if (div_stat.done) qr_q <= div_quo;
			S_DD: if (div_stat.done) qd_q <= div_quo;
			S_MUL: if (mul_stat.done) acc_q <= mul_res;
			default: ;
		endcase
		// Hold r across primes in a copy that the divider does not overwrite.
		if (accept)
			qr_q <= item.r_value;
		else if (state_q == S_LOOP)
			qr_q <= r_keep_q;
		if (state_q == S_CHK)
			e_q <= '0;
		else if ((state_q == S_DD) && div_stat.done)
			e_q <= e_new;
		else if ((state_q == S_MUL) && mul_stat.done)
			e_q <= e_q - 1'b1;
		if (strobe_d)
			result_q <= result_d;
	end

	always_ff @(posedge clk) begin
		if (accept)
			r_keep_q <= item.r_value;
	end

	always_comb begin
		strobe_d = 1'b0;
		result_d = '{residue: acc_q, error: 1'b0};
		if (accept && (item.modulus == 32'd0)) begin
			strobe_d = 1'b1;
			result_d = '{residue: 32'd0, error: 1'b1};
		end else if (accept && (item.r_value > item.n_value)) begin
			strobe_d = 1'b1;
			result_d = '{residue: 32'd0, error: 1'b0};
		end else if ((state_q == S_LOOP) && ((p_q > {1'b0, n_q}) || (acc_q == 32'd0))) begin
			strobe_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			p_q        <= '0;
			launched_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item.modulus != 32'd0) &&
						(item.r_value <= item.n_value)) begin
						p_q     <= 17'd2;
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if ((p_q > {1'b0, n_q}) || (acc_q == 32'd0))
						state_q <= S_IDLE;
					else
						state_q <= S_CHK;
				end
				S_CHK: begin
					if (map_data) begin
						p_q     <= p_q + 1'b1;
						state_q <= S_LOOP;
					end else begin
						state_q <= S_DN;
					end
				end
				S_DN, S_DR: begin
					if (div_start)
						launched_q <= 1'b1;
					else if (div_stat.done) begin
						launched_q <= 1'b0;
						state_q    <= (state_q == S_DN) ? S_DR : S_DD;
					end
				end
				S_DD: begin
					if (div_start)
						launched_q <= 1'b1;
					else if (div_stat.done) begin
						launched_q <= 1'b0;
						// Stop once n has run out of base-p digits.
						if (qn_q == 16'd0) begin
							if (e_new == 5'd0) begin
								p_q     <= p_q + 1'b1;
								state_q <= S_LOOP;
							end else begin
								state_q <= S_MUL;
							end
						end else begin
							state_q <= S_DN;
						end
					end
				end
				S_MUL: begin
					if (mul_start)
						launched_q <= 1'b1;
					else if (mul_stat.done) begin
						launched_q <= 1'b0;
						if (e_q == 5'd1) begin
							p_q     <= p_q + 1'b1;
							state_q <= S_LOOP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`ASSERT_NEXT(a_zero_mod_err, clk, arst_n, accept && (item.modulus == 32'd0), strobe && result.error)
	`ASSERT_IMPLIES(a_err_res_zero, clk, arst_n, strobe && result.error, result.residue == 32'd0)
	`ASSERT_IMPLIES(a_res_below_m, clk, arst_n, strobe && !result.error, result.residue < m_q)
endmodule
